FILE: hdl/ccs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccs_pkg: shared types and constants
// Phase codes, configuration register indexes, reset values and the
// structs passed between the cleaning cycle sequencer modules.
// ----------------------------------------------------------------------------
package ccs_pkg;

    // Default blink period of the status LED in error, in ticks
    localparam int BLINK_PERIOD_DEF = 200;

    localparam int TICK_W  = 20;
    localparam int BASE_W  = 16;
    localparam int SCALE_W = 4;
    localparam int HIT_W   = 8;
    localparam int ACT_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
    localparam logic [HIT_W-1:0]  HIT_MAX  = {HIT_W{1'b1}};

    // Reset values of the configuration registers
    localparam logic [BASE_W-1:0]  SUCTION_TIME_RST = 16'd5000;
    localparam logic [BASE_W-1:0]  WASH_TIME_RST    = 16'd10000;
    localparam logic [BASE_W-1:0]  DRY_TIME_RST     = 16'd30000;
    localparam logic [SCALE_W-1:0] FECES_SCALE_RST  = 4'd2;
    localparam logic [HIT_W-1:0]   DEBOUNCE_RST     = 8'd3;

    // Actuator bit masks
    localparam logic [ACT_W-1:0] ACT_SUCTION = 4'b0001;
    localparam logic [ACT_W-1:0] ACT_WATER   = 4'b0010;
    localparam logic [ACT_W-1:0] ACT_DRY     = 4'b1100;
    localparam logic [ACT_W-1:0] ACT_NONE    = 4'b0000;

    // Sample class of a normal reading
    localparam logic [1:0] CLASS_NORMAL = 2'd0;

    typedef enum logic [2:0] {
        PH_MONITOR  = 3'd0,
        PH_DETECTED = 3'd1,
        PH_SUCTION  = 3'd2,
        PH_WASH     = 3'd3,
        PH_DRY      = 3'd4,
        PH_COMPLETE = 3'd5,
        PH_ERROR    = 3'd6
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SUCTION_TIME = 3'd0,
        CFG_WASH_TIME    = 3'd1,
        CFG_DRY_TIME     = 3'd2,
        CFG_FECES_SCALE  = 3'd3,
        CFG_DEBOUNCE     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [BASE_W-1:0]  suction_time;
        logic [BASE_W-1:0]  wash_time;
        logic [BASE_W-1:0]  dry_time;
        logic [SCALE_W-1:0] feces_scale;
        logic [HIT_W-1:0]   debounce_needed;
    } t_cfg;

    typedef struct packed {
        logic       stop_pressed;
        logic       sample_valid;
        logic [1:0] sample_class;
    } t_item;

    typedef struct packed {
        t_phase           phase;
        logic [ACT_W-1:0] act;
        logic             led;
        logic             kind;
    } t_status;

endpackage
`default_nettype wire

FILE: hdl/ccs_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccs_cfg: configuration registers
// Holds the phase durations, feces multiplier and debounce count.
// ----------------------------------------------------------------------------
module ccs_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ccs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ccs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output ccs_pkg::t_cfg                       o_cfg
);
    import ccs_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.suction_time    <= SUCTION_TIME_RST;
            r_cfg.wash_time       <= WASH_TIME_RST;
            r_cfg.dry_time        <= DRY_TIME_RST;
            r_cfg.feces_scale     <= FECES_SCALE_RST;
            r_cfg.debounce_needed <= DEBOUNCE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SUCTION_TIME: r_cfg.suction_time    <= i_cfg_data;
                CFG_WASH_TIME:    r_cfg.wash_time       <= i_cfg_data;
                CFG_DRY_TIME:     r_cfg.dry_time        <= i_cfg_data;
                CFG_FECES_SCALE:  r_cfg.feces_scale     <= i_cfg_data[SCALE_W-1:0];
                CFG_DEBOUNCE:     r_cfg.debounce_needed <= i_cfg_data[HIT_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

FILE: hdl/ccs_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccs_step: per-tick state update
// Phase machine, phase timer, debounce counter, LED and actuator state.
// The registers here also form the result register.
// ----------------------------------------------------------------------------
module ccs_step #(
    parameter int BLINK_PERIOD = ccs_pkg::BLINK_PERIOD_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_proc,
    input  ccs_pkg::t_item i_item,
    input  ccs_pkg::t_cfg  i_cfg,
    output ccs_pkg::t_status o_status
);
    import ccs_pkg::*;

    localparam int BW = $clog2(BLINK_PERIOD + 1);
    localparam logic [BW-1:0] BLINK_LIM = BW'(BLINK_PERIOD);

    t_phase             r_phase, n_phase;
    logic [TICK_W-1:0]  r_ticks, n_ticks;
    logic [HIT_W-1:0]   r_hit, n_hit;
    logic               r_kind, n_kind;
    logic               r_led, n_led;
    logic [BW-1:0]      r_blink, n_blink;
    logic [ACT_W-1:0]   r_act, n_act;

    logic [BASE_W-1:0]  w_base;
    logic [TICK_W-1:0]  w_limit;
    logic [TICK_W-1:0]  w_ticks_inc;
    logic               w_run;
    logic [HIT_W-1:0]   w_hit_inc;
    logic               w_hit_sample;
    logic               w_detect;
    logic [BW-1:0]      w_blink_inc;
    logic               w_blink_hit;
    logic [ACT_W-1:0]   w_bits;

    // Phase length: base time, scaled for feces cycles
    always_comb begin
        case (r_phase)
            PH_SUCTION: w_base = i_cfg.suction_time;
            PH_WASH:    w_base = i_cfg.wash_time;
            default:    w_base = i_cfg.dry_time;
        endcase
    end

    always_comb begin
        case (r_phase)
            PH_SUCTION: w_bits = ACT_SUCTION;
            PH_WASH:    w_bits = ACT_WATER;
            default:    w_bits = ACT_DRY;
        endcase
    end

    assign w_limit = r_kind ? TICK_W'(w_base) * TICK_W'(i_cfg.feces_scale)
                            : TICK_W'(w_base);
    assign w_ticks_inc  = (r_ticks == TICK_MAX) ? r_ticks : r_ticks + 1'b1;
    assign w_run        = w_ticks_inc < w_limit;
    assign w_hit_inc    = (r_hit == HIT_MAX) ? r_hit : r_hit + 1'b1;
    assign w_hit_sample = i_item.sample_valid && (i_item.sample_class != CLASS_NORMAL);
    assign w_detect     = w_hit_sample && (w_hit_inc >= i_cfg.debounce_needed);
    assign w_blink_inc  = r_blink + 1'b1;
    assign w_blink_hit  = w_blink_inc >= BLINK_LIM;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_DETECTED: n_phase = PH_SUCTION;
            PH_SUCTION: begin
                if (i_item.stop_pressed) n_phase = PH_ERROR;
                else if (!w_run)         n_phase = PH_WASH;
            end
            PH_WASH: begin
                if (i_item.stop_pressed) n_phase = PH_ERROR;
                else if (!w_run)         n_phase = PH_DRY;
            end
            PH_DRY: begin
                if (i_item.stop_pressed) n_phase = PH_ERROR;
                else if (!w_run)         n_phase = PH_COMPLETE;
            end
            PH_COMPLETE: n_phase = PH_MONITOR;
            PH_ERROR: begin
                if (w_blink_hit && !i_item.stop_pressed) n_phase = PH_MONITOR;
            end
            default: begin
                n_phase = w_detect ? PH_DETECTED : PH_MONITOR;
            end
        endcase
    end

    // Timer, counters, LED and actuators
    always_comb begin
        n_ticks = r_ticks;
        n_hit   = r_hit;
        n_kind  = r_kind;
        n_led   = r_led;
        n_blink = r_blink;
        n_act   = r_act;
        case (r_phase)
            PH_DETECTED: n_ticks = '0;
            PH_SUCTION, PH_WASH, PH_DRY: begin
                if (i_item.stop_pressed) begin
                    n_act   = ACT_NONE;
                    n_blink = '0;
                end else if (w_run) begin
                    n_act   = r_act | w_bits;
                    n_ticks = w_ticks_inc;
                end else begin
                    n_act   = (r_phase == PH_DRY) ? ACT_NONE : (r_act & ~w_bits);
                    n_ticks = '0;
                end
            end
            PH_COMPLETE: n_hit = '0;
            PH_ERROR: begin
                n_act = ACT_NONE;
                if (w_blink_hit) begin
                    n_blink = '0;
                    n_led   = ~r_led;
                end else begin
                    n_blink = w_blink_inc;
                end
            end
            default: begin
                n_act = ACT_NONE;
                if (i_item.sample_valid) begin
                    if (w_hit_sample) begin
                        // classes two and three count as feces
                        n_hit = w_detect ? '0 : w_hit_inc;
                        if (w_detect) n_kind = i_item.sample_class[1];
                    end else begin
                        n_hit = '0;
                    end
                    n_led = ~r_led;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MONITOR;
            r_ticks <= '0;
            r_hit   <= '0;
            r_kind  <= 1'b0;
            r_led   <= 1'b0;
            r_blink <= '0;
            r_act   <= ACT_NONE;
        end else if (i_proc) begin
            r_phase <= n_phase;
            r_ticks <= n_ticks;
            r_hit   <= n_hit;
            r_kind  <= n_kind;
            r_led   <= n_led;
            r_blink <= n_blink;
            r_act   <= n_act;
        end
    end

    assign o_status.phase = r_phase;
    assign o_status.act   = r_act;
    assign o_status.led   = r_led;
    assign o_status.kind  = r_kind;

`ifndef SYNTHESIS
    a_error_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ERROR) |-> (r_act == ACT_NONE))
        else $error("actuator on in error phase");

    a_hit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_MONITOR) |-> (r_hit == '0))
        else $error("debounce count held outside monitoring");

    a_blink_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blink < BLINK_LIM)
        else $error("blink counter past its period");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_proc |=> $stable(r_phase) && $stable(r_ticks) && $stable(r_led))
        else $error("state moved without a tick");
`endif

endmodule
`default_nettype wire

FILE: hdl/timed_cleaning_cycle_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// timed_cleaning_cycle_sequencer: cleaning cycle sequencer top level
// Debounces classification samples, runs timed suction, wash and dry
// phases, and traps to an error phase on emergency stop.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-----------------------------
//   in      | input     | i_in_valid / o_in_stall  | stop, sample valid, class
//   out     | output    | o_out_valid / i_out_stall| phase, 4 drives, led, kind
//   cfg     | input     | i_cfg_we                 | i_cfg_index, i_cfg_data
//
// One tick per clock: an accepted tick lands in the input register and
// is applied to the state once the result slot is free; the updated
// state registers are the result. The state update is one pass of
// short logic (one 16x4 multiply and a 20-bit compare), so a new tick is
// taken every cycle while the output side keeps up.
// Reset (synchronous, active low) restores all register reset values,
// empties both stages and puts the machine in monitoring.
// A stall on the output holds the result and, once the input register is
// full, raises the input stall; nothing is dropped.
// ----------------------------------------------------------------------------
module timed_cleaning_cycle_sequencer #(
    parameter int BLINK_PERIOD = ccs_pkg::BLINK_PERIOD_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // tick input
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_stop_pressed,
    input  wire logic                           i_sample_valid,
    input  wire logic [1:0]                     i_sample_class,
    // result output
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [2:0]                          o_phase,
    output logic                                o_suction_on,
    output logic                                o_water_on,
    output logic                                o_heater_on,
    output logic                                o_fan_on,
    output logic                                o_status_led,
    output logic                                o_cycle_kind,
    // configuration writes
    input  wire logic                           i_cfg_we,
    input  wire logic [ccs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ccs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ccs_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    logic    w_out_free;
    logic    w_proc;
    logic    w_in_take;
    t_cfg    w_cfg;
    t_status w_status;

    // The result slot is free when empty or being taken this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;
    // Apply the held tick when its result has a place to go
    assign w_proc     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // advance the input stage: refill on transfer, empty once applied
            if (w_in_take)   r_in_valid <= 1'b1;
            else if (w_proc) r_in_valid <= 1'b0;
            // result is valid after an update until the consumer takes it
            if (w_proc)          r_out_valid <= 1'b1;
            else if (w_out_free) r_out_valid <= 1'b0;
        end
    end

    // Payload: load on transfer, hold otherwise
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_item.stop_pressed <= i_stop_pressed;
            r_item.sample_valid <= i_sample_valid;
            r_item.sample_class <= i_sample_class;
        end
    end

    ccs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // State update; its registers double as the result register
    ccs_step #(
        .BLINK_PERIOD (BLINK_PERIOD)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_proc   (w_proc),
        .i_item   (r_item),
        .i_cfg    (w_cfg),
        .o_status (w_status)
    );

    assign o_out_valid  = r_out_valid;
    assign o_phase      = w_status.phase;
    assign o_suction_on = w_status.act[0];
    assign o_water_on   = w_status.act[1];
    assign o_heater_on  = w_status.act[2];
    assign o_fan_on     = w_status.act[3];
    assign o_status_led = w_status.led;
    assign o_cycle_kind = w_status.kind;

endmodule
`default_nettype wire
